FILE: rtl/detection_box_merge_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the detection box merge table
// Shared shorthand for clocked assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef DETECTION_BOX_MERGE_TABLE_ASSERT_SVH
`define DETECTION_BOX_MERGE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBMT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dbmt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DBMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dbmt assertion failed");

`endif

FILE: rtl/dbmt_pkg.sv
// ----------------------------------------------------------------------------
// Detection box merge table package
// Shared widths, rectangle type, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dbmt_pkg;

	localparam int COORD_BITS      = 10;
	localparam int SUM_W           = COORD_BITS + 1;
	localparam int MAX_BOXES_DEF   = 32;

	localparam int CMD_W           = 2;
	localparam int STATUS_W        = 3;
	localparam int IDX_IN_W        = 5;
	localparam int IDX_OUT_W       = 5;
	localparam int CNT_OUT_W       = 6;

	localparam int IN_FIELDS_W     = 4 * COORD_BITS + IDX_IN_W;
	localparam int IN_TDATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W    = IDX_OUT_W + CNT_OUT_W + 4 * COORD_BITS;
	localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W       = OUT_TDATA_W - OUT_FIELDS_W;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [SUM_W-1:0]      sum_t;

	localparam coord_t COORD_MAX = '1;

	typedef struct packed {
		coord_t h;
		coord_t w;
		coord_t y;
		coord_t x;
	} rect_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_APPENDED   = 3'd0,
		STAT_MERGED     = 3'd1,
		STAT_DROPPED    = 3'd2,
		STAT_READ_OK    = 3'd3,
		STAT_CLEARED    = 3'd4,
		STAT_READ_EMPTY = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MERGE,
		S_RDWAIT,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/dbmt_merge.sv
// ----------------------------------------------------------------------------
// Box merge unit
// Center containment test against one stored entry, and a registered
// bounding-union stage that produces the merged rectangle.
// ----------------------------------------------------------------------------
`default_nettype none

module dbmt_merge (
	input  logic            clk,
	input  logic            load,
	input  dbmt_pkg::rect_t new_rect,
	input  dbmt_pkg::rect_t entry,
	input  dbmt_pkg::sum_t  cx,
	input  dbmt_pkg::sum_t  cy,
	output logic            hit,
	output dbmt_pkg::rect_t merged
);
	import dbmt_pkg::*;

	sum_t   e_right, e_bottom, n_right, n_bottom;
	sum_t   right_s1, bottom_s1;
	coord_t left_s1, top_s1;
	sum_t   span_w, span_h;

	assign e_right  = sum_t'(entry.x) + sum_t'(entry.w);
	assign e_bottom = sum_t'(entry.y) + sum_t'(entry.h);
	assign n_right  = sum_t'(new_rect.x) + sum_t'(new_rect.w);
	assign n_bottom = sum_t'(new_rect.y) + sum_t'(new_rect.h);

	// The center must lie strictly inside the stored entry.
	assign hit = (sum_t'(entry.x) < cx) && (e_right > cx) &&
		(sum_t'(entry.y) < cy) && (e_bottom > cy);

	always_ff @(posedge clk) begin
		if (load) begin
			right_s1  <= (n_right > e_right) ? n_right : e_right;
			bottom_s1 <= (n_bottom > e_bottom) ? n_bottom : e_bottom;
			left_s1   <= (new_rect.x < entry.x) ? new_rect.x : entry.x;
			top_s1    <= (new_rect.y < entry.y) ? new_rect.y : entry.y;
		end
	end

	// Width and height follow the new left and top edges; an overflow saturates.
	assign span_w = right_s1 - sum_t'(left_s1);
	assign span_h = bottom_s1 - sum_t'(top_s1);

	always_comb begin
		merged.x = left_s1;
		merged.y = top_s1;
		merged.w = span_w[COORD_BITS] ? COORD_MAX : span_w[COORD_BITS-1:0];
		merged.h = span_h[COORD_BITS] ? COORD_MAX : span_h[COORD_BITS-1:0];
	end

endmodule

`default_nettype wire

FILE: rtl/detection_box_merge_table.sv
// ----------------------------------------------------------------------------
// Detection box merge table
// Keeps up to MAX_BOXES detection rectangles, merges an insert whose center lies inside a stored one.
// ----------------------------------------------------------------------------
// Usage: one command word enters on the s_ stream, the kind in s_tuser
// (insert, read, clear). Each insert, read or clear gives exactly one result
// word on the m_ stream, its status in m_tuser; the unused command code is
// taken and gives no result.
// An insert scans the stored entries in order through the box memory, one
// read a cycle. When it appends or drops, its result is loaded once the
// scan has passed every stored entry; when its center lies inside an entry,
// the scan stops there and the merge state writes the union back first. The
// box memory has a single read port. A read of a stored entry passes through
// the read-wait state; a read past the count and a clear go straight on.
// The next command is taken in the cycle after a result is loaded.
// The block works on one command at a time; s_tready is high while it is
// idle. A finished result sits in the output register, so the next command
// is taken while the receiver stalls; the block then waits at its own
// result until the output register frees up.
// Reset empties the table at once (the stored count goes to zero); the box
// memory itself is not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_box_merge_table #(
	parameter int MAX_BOXES = dbmt_pkg::MAX_BOXES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// box_x, box_y, box_w, box_h, read_index, zero fill
	input  logic [dbmt_pkg::IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic [dbmt_pkg::CMD_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// entry_index, box_count, out_x, out_y, out_w, out_h, zero fill
	output logic [dbmt_pkg::OUT_TDATA_W-1:0] m_tdata,
	// status
	output logic [dbmt_pkg::STATUS_W-1:0]    m_tuser
);
	import dbmt_pkg::*;

	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

	state_t               state_q, state_nxt;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     rd_ptr_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic [IDX_W-1:0]     hit_idx_q;
	rect_t                rect_q;
	sum_t                 cx_q, cy_q;
	status_t              res_status_q;
	logic [IDX_OUT_W-1:0] res_idx_q;
	rect_t                res_rect_q;
	logic                 m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]  m_tuser_q;

	rect_t                box_mem [MAX_BOXES];
	rect_t                rd_data;
	logic                 mem_re, mem_we;
	logic [IDX_W-1:0]     mem_raddr, mem_waddr;
	rect_t                mem_wdata;

	rect_t                in_rect;
	logic [IDX_IN_W-1:0]  in_idx;
	cmd_t                 in_cmd;
	logic                 in_acc;
	logic                 read_hit;
	logic                 hit;
	logic                 scan_hit;
	logic                 scan_issue;
	logic                 table_full;
	logic                 out_free;
	rect_t                merged;

	assign in_rect.x = s_tdata[0 +: COORD_BITS];
	assign in_rect.y = s_tdata[COORD_BITS +: COORD_BITS];
	assign in_rect.w = s_tdata[2*COORD_BITS +: COORD_BITS];
	assign in_rect.h = s_tdata[3*COORD_BITS +: COORD_BITS];
	assign in_idx    = s_tdata[4*COORD_BITS +: IDX_IN_W];
	assign in_cmd    = cmd_t'(s_tuser);

	assign read_hit   = CMP_W'(in_idx) < CMP_W'(count_q);
	assign table_full = (count_q == CNT_W'(MAX_BOXES));
	assign scan_hit   = cmp_vld_s1 && hit;
	assign out_free   = !m_tvalid_q || m_tready;

	dbmt_merge u_merge (
		.clk      (clk),
		.load     (state_q == S_SCAN && scan_hit),
		.new_rect (rect_q),
		.entry    (rd_data),
		.cx       (cx_q),
		.cy       (cy_q),
		.hit      (hit),
		.merged   (merged)
	);

	// Memory and handshake controls.
	always_comb begin
		s_tready   = (state_q == S_IDLE);
		in_acc     = s_tvalid && s_tready;
		mem_re     = 1'b0;
		mem_raddr  = rd_ptr_q[IDX_W-1:0];
		mem_we     = 1'b0;
		mem_waddr  = count_q[IDX_W-1:0];
		mem_wdata  = rect_q;
		scan_issue = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc && in_cmd == CMD_READ && read_hit) begin
					mem_re    = 1'b1;
					mem_raddr = IDX_W'(in_idx);
				end
			end
			S_SCAN: begin
				scan_issue = (rd_ptr_q < count_q) && !scan_hit;
				mem_re     = scan_issue;
				if (!scan_hit && !scan_issue && !table_full) begin
					mem_we = 1'b1;
				end
			end
			S_MERGE: begin
				mem_we    = 1'b1;
				mem_waddr = hit_idx_q;
				mem_wdata = merged;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (in_cmd)
						CMD_INSERT: state_nxt = S_SCAN;
						CMD_READ:   state_nxt = read_hit ? S_RDWAIT : S_OUT;
						CMD_CLEAR:  state_nxt = S_OUT;
						default:    state_nxt = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					state_nxt = S_MERGE;
				end else if (!scan_issue) begin
					state_nxt = S_OUT;
				end
			end
			S_MERGE:  state_nxt = S_OUT;
			S_RDWAIT: state_nxt = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			box_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data <= box_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			cmp_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_cmd == CMD_CLEAR) begin
						count_q <= '0;
					end
					cmp_vld_s1 <= 1'b0;
				end
				S_SCAN: begin
					cmp_vld_s1 <= scan_issue;
					if (!scan_hit && !scan_issue && !table_full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rect_q   <= in_rect;
				cx_q     <= sum_t'(in_rect.x) + sum_t'(in_rect.w >> 1);
				cy_q     <= sum_t'(in_rect.y) + sum_t'(in_rect.h >> 1);
				rd_ptr_q <= '0;
				res_rect_q <= '0;
				if (in_cmd == CMD_CLEAR) begin
					res_status_q <= STAT_CLEARED;
					res_idx_q    <= '0;
				end else begin
					res_status_q <= read_hit ? STAT_READ_OK : STAT_READ_EMPTY;
					res_idx_q    <= in_idx;
				end
			end
			S_SCAN: begin
				if (scan_issue) begin
					rd_ptr_q <= rd_ptr_q + CNT_W'(1);
				end
				cmp_idx_s1 <= rd_ptr_q[IDX_W-1:0];
				hit_idx_q  <= cmp_idx_s1;
				res_rect_q <= rect_q;
				if (table_full) begin
					res_status_q <= STAT_DROPPED;
					res_idx_q    <= '0;
				end else begin
					res_status_q <= STAT_APPENDED;
					res_idx_q    <= IDX_OUT_W'(count_q);
				end
			end
			S_MERGE: begin
				res_status_q <= STAT_MERGED;
				res_idx_q    <= IDX_OUT_W'(hit_idx_q);
				res_rect_q   <= merged;
			end
			S_RDWAIT: begin
				res_rect_q <= rd_data;
			end
			S_OUT: begin
				if (out_free) begin
					m_tuser_q <= res_status_q;
					m_tdata_q <= {{OUT_PAD_W{1'b0}}, res_rect_q.h, res_rect_q.w,
						res_rect_q.y, res_rect_q.x, CNT_OUT_W'(count_q), res_idx_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

FILE: rtl/dbmt_checker.sv
// ----------------------------------------------------------------------------
// Detection box merge table port checker
// Watches the top-level streams and flags result words that break the rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "detection_box_merge_table_assert.svh"

module dbmt_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [dbmt_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic [dbmt_pkg::STATUS_W-1:0]    m_tuser
);
	import dbmt_pkg::*;

	logic stalled;
	logic clr_word;
	logic empty_word;
	logic rect_zero;
	logic meta_zero;

	localparam int RECT_LSB = IDX_OUT_W + CNT_OUT_W;

	assign stalled    = m_tvalid && !m_tready;
	assign clr_word   = m_tvalid && (m_tuser == STAT_CLEARED);
	assign empty_word = m_tvalid && (m_tuser == STAT_READ_EMPTY);
	assign rect_zero  = (m_tdata[RECT_LSB +: 4*COORD_BITS] == '0);
	assign meta_zero  = (m_tdata[0 +: RECT_LSB] == '0);

	`DBMT_ASSERT_NEXT(a_stall_holds_valid, stalled, m_tvalid)
	`DBMT_ASSERT_NEXT(a_stall_holds_word, stalled, $stable(m_tdata) && $stable(m_tuser))
	`DBMT_ASSERT_SAME(a_clear_word_zero, clr_word, meta_zero && rect_zero)
	`DBMT_ASSERT_SAME(a_empty_read_zero, empty_word, rect_zero)

endmodule

bind detection_box_merge_table dbmt_checker u_dbmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
